FILE: rtl/bed_pkg.sv
// ---------------------------------------------------------------------------
// bed_pkg
// Shared types and constants for the backslash escape decoder.
// ---------------------------------------------------------------------------
package bed_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPES_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_APPEND_NEWLINE = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  // Most results one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  // Decode phase, one-hot.
  typedef enum logic [5:0] {
    PH_PLAIN = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_HEX0  = 6'b000100,
    PH_HEX1  = 6'b001000,
    PH_OCT1  = 6'b010000,
    PH_OCT2  = 6'b100000
  } phase_t;

  // Results of one input byte, handed from the decoder to the output queue.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    empty;
    logic                    last;
  } bundle_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    case (b) inside
      [8'h30:8'h39]: r = {1'b1, 4'(b - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(b - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(b - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/bed_decode.sv
// ---------------------------------------------------------------------------
// bed_decode
// Escape phase register and the decode of one byte into up to three results.
// ---------------------------------------------------------------------------
module bed_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              escapes_enable,
  input  logic              append_newline,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output bed_pkg::bundle_t  bundle
);

  bed_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      val_r, val_nxt;

  // Candidate results in output order: main, byte after a flush,
  // escape value open at the end, appended newline.
  logic [3:0]       ev;
  logic [3:0][7:0]  eb;
  logic [4:0]       hx;
  logic             is_oct;
  logic [7:0]       hacc;
  logic [7:0]       oacc;
  logic [1:0]       n;

  assign hx     = bed_pkg::hex_digit(in_byte);
  assign is_oct = (in_byte >= 8'h30) && (in_byte <= 8'h37);
  assign hacc   = {val_r[3:0], hx[3:0]};
  assign oacc   = {val_r[4:0], in_byte[2:0]};

  // Next phase and the results of this byte.
  always_comb begin
    phase_nxt = phase_r;
    val_nxt   = val_r;
    ev        = '0;
    eb        = '0;
    if (!escapes_enable) begin
      phase_nxt = bed_pkg::PH_PLAIN;
      val_nxt   = 8'd0;
      ev[0]     = 1'b1;
      eb[0]     = in_byte;
    end else begin
      case (phase_r)
        bed_pkg::PH_ESC: begin
          phase_nxt = bed_pkg::PH_PLAIN;
          if (in_byte == bed_pkg::CH_N) begin
            ev[0] = 1'b1;
            eb[0] = bed_pkg::CH_LF;
          end else if (in_byte == bed_pkg::CH_T) begin
            ev[0] = 1'b1;
            eb[0] = bed_pkg::CH_TAB;
          end else if (in_byte == bed_pkg::CH_R) begin
            ev[0] = 1'b1;
            eb[0] = bed_pkg::CH_CR;
          end else if (in_byte == bed_pkg::CH_X) begin
            phase_nxt = bed_pkg::PH_HEX0;
            val_nxt   = 8'd0;
          end else if (in_byte == bed_pkg::CH_ZERO) begin
            phase_nxt = bed_pkg::PH_OCT1;
            val_nxt   = 8'd0;
          end
        end
        bed_pkg::PH_HEX0, bed_pkg::PH_HEX1: begin
          if (hx[4]) begin
            if (phase_r == bed_pkg::PH_HEX1) begin
              ev[0]     = 1'b1;
              eb[0]     = hacc;
              phase_nxt = bed_pkg::PH_PLAIN;
              val_nxt   = 8'd0;
            end else begin
              phase_nxt = bed_pkg::PH_HEX1;
              val_nxt   = hacc;
            end
          end else begin
            ev[0]   = 1'b1;
            eb[0]   = val_r;
            val_nxt = 8'd0;
            if (in_byte == bed_pkg::CH_BACKSLASH) begin
              phase_nxt = bed_pkg::PH_ESC;
            end else begin
              phase_nxt = bed_pkg::PH_PLAIN;
              ev[1]     = 1'b1;
              eb[1]     = in_byte;
            end
          end
        end
        bed_pkg::PH_OCT1, bed_pkg::PH_OCT2: begin
          if (is_oct) begin
            if (phase_r == bed_pkg::PH_OCT2) begin
              ev[0]     = 1'b1;
              eb[0]     = oacc;
              phase_nxt = bed_pkg::PH_PLAIN;
              val_nxt   = 8'd0;
            end else begin
              phase_nxt = bed_pkg::PH_OCT2;
              val_nxt   = oacc;
            end
          end else begin
            ev[0]   = 1'b1;
            eb[0]   = val_r;
            val_nxt = 8'd0;
            if (in_byte == bed_pkg::CH_BACKSLASH) begin
              phase_nxt = bed_pkg::PH_ESC;
            end else begin
              phase_nxt = bed_pkg::PH_PLAIN;
              ev[1]     = 1'b1;
              eb[1]     = in_byte;
            end
          end
        end
        default: begin
          // Plain text, and any code that means nothing.
          if (in_byte == bed_pkg::CH_BACKSLASH) begin
            phase_nxt = bed_pkg::PH_ESC;
          end else begin
            phase_nxt = bed_pkg::PH_PLAIN;
            ev[0]     = 1'b1;
            eb[0]     = in_byte;
          end
        end
      endcase
    end

    // End of text: flush an open numeric escape, append a newline, reset.
    if (in_last) begin
      if (phase_nxt == bed_pkg::PH_HEX0 || phase_nxt == bed_pkg::PH_HEX1 ||
          phase_nxt == bed_pkg::PH_OCT1 || phase_nxt == bed_pkg::PH_OCT2) begin
        ev[2] = 1'b1;
        eb[2] = val_nxt;
      end
      ev[3]     = append_newline;
      eb[3]     = bed_pkg::CH_LF;
      phase_nxt = bed_pkg::PH_PLAIN;
      val_nxt   = 8'd0;
    end
  end

  // Pack the candidates into consecutive slots.
  always_comb begin
    n            = 2'd0;
    bundle.bytes = '0;
    for (int i = 0; i < 4; i++) begin
      if (ev[i]) begin
        bundle.bytes[n] = eb[i];
        n               = n + 2'd1;
      end
    end
    bundle.empty = in_last && (n == 2'd0);
    bundle.cnt   = bundle.empty ? 2'd1 : n;
    bundle.last  = in_last;
  end

  // Phase and value registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bed_pkg::PH_PLAIN;
      val_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      val_r   <= val_nxt;
    end
  end

endmodule

FILE: rtl/bed_outq.sv
// ---------------------------------------------------------------------------
// bed_outq
// Result register for a byte's results, sent out one per cycle on out_ready.
// ---------------------------------------------------------------------------
module bed_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  bed_pkg::bundle_t  bundle,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_empty,
  output logic              out_last
);

  logic [bed_pkg::MAX_RES-1:0][7:0] bytes_r;
  logic [1:0]                       cnt_r;
  logic                             empty_r;
  logic                             last_r;
  logic                             out_fire;

  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte  = empty_r ? 8'd0 : bytes_r[0];
  assign out_empty = empty_r;
  assign out_last  = last_r && (cnt_r == 2'd1);

  // Count and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      empty_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (in_valid && in_ready) begin
      cnt_r   <= bundle.cnt;
      empty_r <= bundle.empty;
      last_r  <= bundle.last;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Result bytes; the head moves down as each result is taken.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bytes_r <= bundle.bytes;
    end else if (out_fire) begin
      bytes_r <= {8'd0, bytes_r[bed_pkg::MAX_RES-1:1]};
    end
  end

endmodule

FILE: rtl/backslash_escape_decoder.sv
// ---------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes backslash escapes in a byte stream and marks the end of the text.
// ---------------------------------------------------------------------------
// Input channel: in_byte with in_last on the final byte of a text, taken
// when in_valid and in_ready are high. Result channel: out_byte, out_empty,
// out_last, taken when out_valid and out_ready are high. A result with
// out_empty high carries only the end mark of a text that produced no byte.
// Configuration channel: cfg_index selects escapes_enable (0) or
// append_newline (1), cfg_data is the bit written; it is always ready and
// should only be written while the block is idle.
// The first result of a byte is offered in the cycle after it is taken.
// Throughput: one byte per cycle while each byte has at most one result and
// the receiver is ready; a byte with more results holds the input until its
// last result leaves; results drain one per cycle while out_ready is high.
// A stalled receiver holds the results steady and stops the input once the
// result register cannot take the next byte's results.
// Reset clears the escape phase and the result register; escapes start
// disabled and the appended newline starts enabled.
// ---------------------------------------------------------------------------
module backslash_escape_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_empty,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                         cfg_data
);

  logic             escapes_enable_r;
  logic             append_newline_r;
  bed_pkg::bundle_t bundle;
  logic             take;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escapes_enable_r <= 1'b0;
      append_newline_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bed_pkg::CFG_ESCAPES_ENABLE: escapes_enable_r <= cfg_data;
        bed_pkg::CFG_APPEND_NEWLINE: append_newline_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte decoder with its phase register.
  bed_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .escapes_enable (escapes_enable_r),
    .append_newline (append_newline_r),
    .take           (take),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .bundle         (bundle)
  );

  // Result register and output sequencing.
  bed_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_empty (out_empty),
    .out_last  (out_last)
  );

endmodule

FILE: dv/bed_decode_checker.sv
// ---------------------------------------------------------------------------
// bed_decode_checker
// Watches the decoder's channels, predicts the decoded result stream and
// compares every result transaction against the oldest expected result.
// ---------------------------------------------------------------------------
module bed_decode_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_byte,
  input  logic                          out_empty,
  input  logic                          out_last,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Character bounds for digit classification.
  localparam logic [7:0] CH_SEVEN   = 8'h37;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;

  typedef struct {
    logic [7:0] data;
    logic       empty;
    logic       last;
  } dec_result_t;

  // Expected results in arrival order, and the bytes of the current step.
  dec_result_t expected_results[$];
  logic [7:0]  step_bytes[$];

  // Predictor copy of the registers and the escape state.
  logic            esc_on;
  logic            nl_on;
  bed_pkg::phase_t phase;
  logic [7:0]      accum;
  int              err_cnt = 0;

  // Value of a hex digit; returns 0 when the byte is not a hex digit.
  function automatic logic hex_value(input logic [7:0] b, output logic [3:0] v);
    v = 4'd0;
    if (b >= bed_pkg::CH_ZERO && b <= CH_NINE) begin
      v = 4'(b - bed_pkg::CH_ZERO);
      return 1'b1;
    end
    if (b >= CH_LOW_A && b <= CH_LOW_F) begin
      v = 4'(b - CH_LOW_A + 8'd10);
      return 1'b1;
    end
    if (b >= CH_UP_A && b <= CH_UP_F) begin
      v = 4'(b - CH_UP_A + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // An ordinary text byte: a backslash opens an escape, anything else passes.
  task automatic plain_text(input logic [7:0] b);
    if (b == bed_pkg::CH_BACKSLASH) begin
      phase = bed_pkg::PH_ESC;
    end else begin
      phase = bed_pkg::PH_PLAIN;
      step_bytes.push_back(b);
    end
  endtask

  // A numeric escape ended by a non-digit: emit its value, then the byte.
  task automatic flush_value(input logic [7:0] b);
    step_bytes.push_back(accum);
    accum = '0;
    plain_text(b);
  endtask

  // Predict the results of one input transaction and queue them.
  task automatic predict_decode(input logic [7:0] b, input logic last);
    logic [3:0] dig;
    step_bytes.delete();
    if (!esc_on) begin
      phase = bed_pkg::PH_PLAIN;
      accum = '0;
      step_bytes.push_back(b);
    end else begin
      case (phase)
        bed_pkg::PH_ESC: begin
          phase = bed_pkg::PH_PLAIN;
          if (b == bed_pkg::CH_N) step_bytes.push_back(bed_pkg::CH_LF);
          else if (b == bed_pkg::CH_T) step_bytes.push_back(bed_pkg::CH_TAB);
          else if (b == bed_pkg::CH_R) step_bytes.push_back(bed_pkg::CH_CR);
          else if (b == bed_pkg::CH_X) begin
            phase = bed_pkg::PH_HEX0;
            accum = '0;
          end else if (b == bed_pkg::CH_ZERO) begin
            phase = bed_pkg::PH_OCT1;
            accum = '0;
          end
        end
        bed_pkg::PH_HEX0, bed_pkg::PH_HEX1: begin
          if (hex_value(b, dig)) begin
            accum = {accum[3:0], dig};
            if (phase == bed_pkg::PH_HEX1) begin
              step_bytes.push_back(accum);
              phase = bed_pkg::PH_PLAIN;
              accum = '0;
            end else begin
              phase = bed_pkg::PH_HEX1;
            end
          end else begin
            flush_value(b);
          end
        end
        bed_pkg::PH_OCT1, bed_pkg::PH_OCT2: begin
          if (b >= bed_pkg::CH_ZERO && b <= CH_SEVEN) begin
            accum = {accum[4:0], b[2:0]};
            if (phase == bed_pkg::PH_OCT2) begin
              step_bytes.push_back(accum);
              phase = bed_pkg::PH_PLAIN;
              accum = '0;
            end else begin
              phase = bed_pkg::PH_OCT2;
            end
          end else begin
            flush_value(b);
          end
        end
        default: begin
          plain_text(b);
        end
      endcase
    end

    // End of text: close an open numeric escape, append the newline and
    // fall back to a bare end mark when nothing else came out.
    if (last) begin
      if (phase inside {bed_pkg::PH_HEX0, bed_pkg::PH_HEX1,
                        bed_pkg::PH_OCT1, bed_pkg::PH_OCT2})
        step_bytes.push_back(accum);
      if (nl_on) step_bytes.push_back(bed_pkg::CH_LF);
      phase = bed_pkg::PH_PLAIN;
      accum = '0;
      if (step_bytes.size() == 0) expected_results.push_back('{8'h00, 1'b1, 1'b1});
    end
    foreach (step_bytes[i]) begin
      expected_results.push_back('{step_bytes[i], 1'b0,
                                   last && (i == step_bytes.size() - 1)});
    end
  endtask

  task automatic report_error(input string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endtask

  // Sample all three channels at the rising edge.
  always @(posedge clk) begin : monitor
    dec_result_t exp_r;
    if (!rst_n) begin
      expected_results.delete();
      esc_on = 1'b0;
      nl_on  = 1'b1;
      phase  = bed_pkg::PH_PLAIN;
      accum  = '0;
    end else begin
      // Result transaction against the oldest expectation.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result: byte %02h empty %0b last %0b",
                                 out_byte, out_empty, out_last));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_byte !== exp_r.data)
            report_error($sformatf("out_byte mismatch: expected %02h, got %02h",
                                   exp_r.data, out_byte));
          if (out_empty !== exp_r.empty)
            report_error($sformatf("out_empty mismatch: expected %0b, got %0b",
                                   exp_r.empty, out_empty));
          if (out_last !== exp_r.last)
            report_error($sformatf("out_last mismatch: expected %0b, got %0b",
                                   exp_r.last, out_last));
        end
      end

      // Register write transaction.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bed_pkg::CFG_ESCAPES_ENABLE) esc_on = cfg_data;
        else if (cfg_index == bed_pkg::CFG_APPEND_NEWLINE) nl_on = cfg_data;
      end

      // Input transaction.
      if (in_valid && in_ready) predict_decode(in_byte, in_last);
    end
    outstanding <= expected_results.size();
    mismatches  <= err_cnt;
  end

endmodule

FILE: dv/backslash_escape_decoder_test.sv
// ---------------------------------------------------------------------------
// backslash_escape_decoder_test
// Drives texts through the escape decoder under all register settings and
// several idle and stall patterns; a side checker predicts and compares.
// ---------------------------------------------------------------------------
module backslash_escape_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS  = 25;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte   = '0;
  logic                          in_last   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_byte;
  logic                          out_empty;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bed_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                          cfg_data  = 1'b0;

  int    mismatches;
  int    outstanding;
  int    gap_pct   = 0;
  int    stall_pct = 0;
  int    bytes_sent = 0;
  int    cycle_cnt = 0;
  string hex_chars = "0123456789abcdefABCDEF";

  // Bytes of the text being built.
  logic [7:0] text_bytes[$];

  backslash_escape_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_empty (out_empty),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bed_decode_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_empty   (out_empty),
    .out_last    (out_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random according to the current pattern.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("backslash_escape_decoder test failed");
    $finish;
  end

  // Offer one byte, with random sender gaps, and wait for the transaction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send the built text; the end mark goes on its final byte if requested.
  task automatic send_built(input logic ends);
    foreach (text_bytes[i]) send_byte(text_bytes[i], ends && (i == text_bytes.size() - 1));
    text_bytes.delete();
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    send_built(ends);
  endtask

  // Wait until every expected result has arrived and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between them.
  task automatic configure(input logic esc, input logic nl);
    cfg_valid <= 1'b1;
    cfg_index <= bed_pkg::CFG_ESCAPES_ENABLE;
    cfg_data  <= esc;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= bed_pkg::CFG_APPEND_NEWLINE;
    cfg_data  <= nl;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Append one random piece of text, mostly well-formed escapes.
  task automatic add_token();
    int kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      text_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 40) begin
      text_bytes.push_back(bed_pkg::CH_BACKSLASH);
      case ($urandom_range(2))
        0: text_bytes.push_back(bed_pkg::CH_N);
        1: text_bytes.push_back(bed_pkg::CH_T);
        default: text_bytes.push_back(bed_pkg::CH_R);
      endcase
    end else if (kind < 60) begin
      // Up to three digits: a third one is plain text again.
      text_bytes.push_back(bed_pkg::CH_BACKSLASH);
      text_bytes.push_back(bed_pkg::CH_X);
      repeat ($urandom_range(3)) text_bytes.push_back(hex_chars[$urandom_range(21)]);
    end else if (kind < 80) begin
      text_bytes.push_back(bed_pkg::CH_BACKSLASH);
      text_bytes.push_back(bed_pkg::CH_ZERO);
      repeat ($urandom_range(3))
        text_bytes.push_back(bed_pkg::CH_ZERO + 8'($urandom_range(7)));
    end else if (kind < 90) begin
      // Unknown escape, or a lone backslash that may end the text.
      text_bytes.push_back(bed_pkg::CH_BACKSLASH);
      if ($urandom_range(1) == 1) text_bytes.push_back(8'($urandom_range(255)));
    end else begin
      text_bytes.push_back(hex_chars[$urandom_range(21)]);
    end
  endtask

  initial begin
    int first_byte;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: simple escapes, hex with two, one and no digits,
    // octal completed by its third digit, unknown escape, trailing backslash.
    configure(1'b1, 1'b1);
    send_text("\\n\\t\\r", 1'b1);
    send_text("\\x4F\\xaZ\\x", 1'b1);
    send_text("\\0178\\q\\", 1'b1);

    // Text that yields nothing carries only the end mark.
    wait_idle();
    configure(1'b1, 1'b0);
    send_text("\\", 1'b1);

    // Disabling escapes in the middle of an open hex escape discards it.
    send_text("\\x4", 1'b0);
    wait_idle();
    configure(1'b0, 1'b0);
    send_text("A", 1'b1);

    // Random texts: every register setting under every idle pattern.
    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      case (ph / 4)
        0: configure(1'b1, 1'b1);
        1: configure(1'b1, 1'b0);
        2: configure(1'b0, 1'b1);
        default: configure(1'b0, 1'b0);
      endcase
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 70;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 70;
        end
        default: begin
          gap_pct   = 15;
          stall_pct = 15;
        end
      endcase
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < PHASE_ITEMS) begin
        repeat ($urandom_range(1, 4)) add_token();
        send_built(1'b1);
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("backslash_escape_decoder test passed");
    end else begin
      $display("backslash_escape_decoder test failed");
    end
    $finish;
  end

endmodule
